### design/ppti_pkg.sv
// ppti_pkg: shared types and constants for the pair potential table interpolator
// no dependencies; imported by ppti_table, ppti_lerp and the top level
`timescale 1ns / 1ps

package ppti_pkg;

  // field widths
  localparam int VAL_W   = 32;  // table value, signed Q16.16
  localparam int DIST_W  = 24;  // distance and config values, unsigned Q8.16
  localparam int IDX_W   = 10;  // load entry index
  localparam int LEN_W   = 11;  // table_len register
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int FRAC_W  = 16;
  localparam int K_W     = 16;  // integer part of the scaled index
  localparam int LIM_W   = K_W + 1;
  localparam int PROD_W  = 2 * DIST_W;
  localparam int WT_W    = FRAC_W + 1;
  localparam int LPROD_W = WT_W + VAL_W;  // weight times entry, signed

  localparam int FRAC_ONE = 65536;

  // default table depth and register reset values
  localparam int TABLE_DEPTH_DFLT = 1024;
  localparam logic [DIST_W-1:0] R_MIN_RST     = 24'd0;
  localparam logic [DIST_W-1:0] INV_DR_RST    = 24'd65536;
  localparam logic [LEN_W-1:0]  TABLE_LEN_RST = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_FORCE  = 2'd0,
    ACT_LOAD_ENERGY = 2'd1,
    ACT_QUERY       = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_R_MIN     = 2'd0,
    CFG_INV_DR    = 2'd1,
    CFG_TABLE_LEN = 2'd2
  } cfg_reg_t;

  // table port control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

### design/ppti_table.sv
// ppti_table: one table memory, one write port and two registered read ports
// depends on ppti_pkg
`timescale 1ns / 1ps

module ppti_table #(
  parameter int DEPTH = ppti_pkg::TABLE_DEPTH_DFLT,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  ppti_pkg::tbl_ctl_t         ctl,
  input  logic [AW-1:0]              waddr,
  input  logic [ppti_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_lo,
  input  logic [AW-1:0]              raddr_hi,
  output logic [ppti_pkg::VAL_W-1:0] rdata_lo,
  output logic [ppti_pkg::VAL_W-1:0] rdata_hi
);
  import ppti_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_lo_r;
  logic [VAL_W-1:0] rdata_hi_r;

  // write and read in the same stage keeps load and query words in order
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_lo_r <= mem[raddr_lo];
      rdata_hi_r <= mem[raddr_hi];
    end
  end

  assign rdata_lo = rdata_lo_r;
  assign rdata_hi = rdata_hi_r;

endmodule

### design/ppti_lerp.sv
// ppti_lerp: weight products of two neighboring entries, then sum and saturate
// depends on ppti_pkg
`timescale 1ns / 1ps

module ppti_lerp (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ppti_pkg::FRAC_W-1:0]       frac,
  input  logic signed [ppti_pkg::VAL_W-1:0] lo,
  input  logic signed [ppti_pkg::VAL_W-1:0] hi,
  output logic signed [ppti_pkg::VAL_W-1:0] result
);
  import ppti_pkg::*;

  logic [WT_W-1:0]              wt_hi;
  logic [WT_W-1:0]              wt_lo;
  logic signed [LPROD_W:0]      ph_full;
  logic signed [LPROD_W:0]      pl_full;
  logic signed [LPROD_W-1:0]    ph_r;
  logic signed [LPROD_W-1:0]    pl_r;
  logic signed [LPROD_W-FRAC_W-1:0] qh;
  logic signed [LPROD_W-FRAC_W-1:0] ql;
  logic signed [LPROD_W-FRAC_W:0]   sum;

  // weights: f for the upper entry, one minus f for the lower
  assign wt_hi = {1'b0, frac};
  assign wt_lo = WT_W'(FRAC_ONE) - {1'b0, frac};

  assign ph_full = $signed({1'b0, wt_hi}) * hi;
  assign pl_full = $signed({1'b0, wt_lo}) * lo;

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_full[LPROD_W-1:0];
      pl_r <= pl_full[LPROD_W-1:0];
    end
  end

  // arithmetic shift by the fraction width is the upper bits
  assign qh  = ph_r[LPROD_W-1:FRAC_W];
  assign ql  = pl_r[LPROD_W-1:FRAC_W];
  assign sum = {qh[LPROD_W-FRAC_W-1], qh} + {ql[LPROD_W-FRAC_W-1], ql};

  // saturate to signed 32 bits
  always_comb begin
    if (sum[LPROD_W-FRAC_W:VAL_W-1] == '0 || sum[LPROD_W-FRAC_W:VAL_W-1] == '1) begin
      result = sum[VAL_W-1:0];
    end else if (sum[LPROD_W-FRAC_W]) begin
      result = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

### design/pair_potential_table_interpolator_unit.sv
// pair_potential_table_interpolator_unit: force and energy table lookup with
// linear interpolation; depends on ppti_pkg, ppti_table and ppti_lerp
//
//   channel  ports                                   direction
//   in       in_valid, in_stall, in_action,          word in
//            in_entry_index, in_entry_value, in_distance
//   out      out_valid, out_stall, out_force_value,  word out
//            out_energy_value, out_status
//   cfg      cfg_wr_en, cfg_index, cfg_wr_data       register write
//
// one word per cycle unless out_stall backs up the pipeline; out_valid rises through
// five register stages: subtract, 24x24 multiply, table read at k and k+1, weight
// multiply, sum/saturate into the output register. loads write the table in the
// same stage queries read it.
// rst_n (synchronous) clears the stage valids and the config registers; tables are
// not cleared. a stalled output lets bubbles close up before in_stall rises.
`timescale 1ns / 1ps

module pair_potential_table_interpolator_unit #(
  parameter int TABLE_DEPTH = ppti_pkg::TABLE_DEPTH_DFLT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppti_pkg::ACT_W-1:0]         in_action,
  input  logic [ppti_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [ppti_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [ppti_pkg::DIST_W-1:0]        in_distance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ppti_pkg::VAL_W-1:0]  out_force_value,
  output logic signed [ppti_pkg::VAL_W-1:0]  out_energy_value,
  output logic [ppti_pkg::STAT_W-1:0]        out_status,
  input  logic                               cfg_wr_en,
  input  logic [ppti_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [ppti_pkg::DIST_W-1:0]        cfg_wr_data
);
  import ppti_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // configuration registers
  logic [DIST_W-1:0] r_min_r;
  logic [DIST_W-1:0] inv_dr_r;
  logic [LEN_W-1:0]  table_len_r;

  // stage enables
  logic en1, en2, en3, en4, en5;
  logic in_accept;

  // stage 1: subtract
  logic              v1_r;
  logic [ACT_W-1:0]  act1_r;
  logic [IDX_W-1:0]  idx1_r;
  logic [VAL_W-1:0]  val1_r;
  logic              below1_r;
  logic [DIST_W-1:0] diff1_r;

  // stage 2: scaled index
  logic              v2_r;
  logic [ACT_W-1:0]  act2_r;
  logic [IDX_W-1:0]  idx2_r;
  logic [VAL_W-1:0]  val2_r;
  logic              below2_r;
  logic [PROD_W-1:0] prod2_r;

  // stage 3: table read data
  logic              v3_r;
  status_t           st3_r;
  logic              use3_r;
  logic [FRAC_W-1:0] frac3_r;

  // stage 4: weight products
  logic              v4_r;
  status_t           st4_r;
  logic              use4_r;

  // output register
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_force_r;
  logic [VAL_W-1:0]  out_energy_r;
  status_t           out_status_r;

  // index math between stage 2 and 3
  logic [K_W-1:0]    k2;
  logic [FRAC_W-1:0] frac2;
  logic [LIM_W-1:0]  limit;
  logic [LIM_W-1:0]  kp1;
  logic              range2;
  status_t           st2;
  logic              use2;
  logic              wr_ok;
  logic [AW-1:0]     raddr_lo;
  logic [AW-1:0]     raddr_hi;
  tbl_ctl_t          force_ctl;
  tbl_ctl_t          energy_ctl;

  logic [VAL_W-1:0]  force_lo, force_hi, energy_lo, energy_hi;
  logic signed [VAL_W-1:0] force_res, energy_res;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_min_r     <= R_MIN_RST;
      inv_dr_r    <= INV_DR_RST;
      table_len_r <= TABLE_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_R_MIN:     r_min_r     <= cfg_wr_data;
        CFG_INV_DR:    inv_dr_r    <= cfg_wr_data;
        CFG_TABLE_LEN: table_len_r <= cfg_wr_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // pipeline flow control: a stage moves when it is empty or its successor moves
  assign en5       = !out_valid_r || !out_stall;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_stall  = !en1;
  assign in_accept = in_valid && en1;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  // stage 1: offset from r_min
  always_ff @(posedge clk) begin
    if (en1) begin
      act1_r   <= in_action;
      idx1_r   <= in_entry_index;
      val1_r   <= in_entry_value;
      below1_r <= in_distance < r_min_r;
      diff1_r  <= in_distance - r_min_r;
    end
  end

  // stage 2: multiply by the reciprocal step
  always_ff @(posedge clk) begin
    if (en2) begin
      act2_r   <= act1_r;
      idx2_r   <= idx1_r;
      val2_r   <= val1_r;
      below2_r <= below1_r;
      prod2_r  <= diff1_r * inv_dr_r;
    end
  end

  // split scaled index and check the upper neighbor against the table length, capped at TABLE_DEPTH
  assign k2     = prod2_r[PROD_W-1:PROD_W-K_W];
  assign frac2  = prod2_r[PROD_W-K_W-1:PROD_W-K_W-FRAC_W];
  assign limit  = (LIM_W'(table_len_r) < LIM_W'(TABLE_DEPTH)) ?
                  LIM_W'(table_len_r) : LIM_W'(TABLE_DEPTH);
  assign kp1    = LIM_W'(k2) + LIM_W'(1);
  assign range2 = kp1 >= limit;

  always_comb begin
    st2  = ST_OK;
    use2 = 1'b0;
    priority if (act2_r != ACT_QUERY) begin
      st2 = ST_OK;
    end else if (below2_r) begin
      st2 = ST_BELOW;
    end else if (range2) begin
      st2 = ST_RANGE;
    end else begin
      use2 = 1'b1;
    end
  end

  // table access: loads write, every advancing word reads
  assign raddr_lo = k2[AW-1:0];
  assign raddr_hi = k2[AW-1:0] + AW'(1);
  assign wr_ok    = v2_r && en3 && (LIM_W'(idx2_r) < LIM_W'(TABLE_DEPTH));

  assign force_ctl.wr_en  = wr_ok && (act2_r == ACT_LOAD_FORCE);
  assign force_ctl.rd_en  = en3;
  assign energy_ctl.wr_en = wr_ok && (act2_r == ACT_LOAD_ENERGY);
  assign energy_ctl.rd_en = en3;

  ppti_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_force_tbl (
    .clk      (clk),
    .ctl      (force_ctl),
    .waddr    (AW'(idx2_r)),
    .wdata    (val2_r),
    .raddr_lo (raddr_lo),
    .raddr_hi (raddr_hi),
    .rdata_lo (force_lo),
    .rdata_hi (force_hi)
  );

  ppti_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_energy_tbl (
    .clk      (clk),
    .ctl      (energy_ctl),
    .waddr    (AW'(idx2_r)),
    .wdata    (val2_r),
    .raddr_lo (raddr_lo),
    .raddr_hi (raddr_hi),
    .rdata_lo (energy_lo),
    .rdata_hi (energy_hi)
  );

  // stage 3 side info
  always_ff @(posedge clk) begin
    if (en3) begin
      st3_r   <= st2;
      use3_r  <= use2;
      frac3_r <= frac2;
    end
  end

  // stage 4: weight products live inside the interpolators
  ppti_lerp u_force_lerp (
    .clk    (clk),
    .en     (en4),
    .frac   (frac3_r),
    .lo     ($signed(force_lo)),
    .hi     ($signed(force_hi)),
    .result (force_res)
  );

  ppti_lerp u_energy_lerp (
    .clk    (clk),
    .en     (en4),
    .frac   (frac3_r),
    .lo     ($signed(energy_lo)),
    .hi     ($signed(energy_hi)),
    .result (energy_res)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      st4_r  <= st3_r;
      use4_r <= use3_r;
    end
  end

  // output register: flagged queries, loads and unused actions give zeros
  always_ff @(posedge clk) begin
    if (en5) begin
      out_force_r  <= use4_r ? force_res  : '0;
      out_energy_r <= use4_r ? energy_res : '0;
      out_status_r <= st4_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_force_value  = out_force_r;
  assign out_energy_value = out_energy_r;
  assign out_status       = out_status_r;

endmodule

### tb/sv/tb_pair_potential_table_interpolator_unit.sv
// tb_pair_potential_table_interpolator_unit: self-checking bench for the table interpolator
// directed table then random load/query traffic under random idle and stall, checked
// word by word against an in-bench interpolation predictor; depends on ppti_pkg and the dut
`timescale 1ns / 1ps

module tb_pair_potential_table_interpolator_unit;
  import ppti_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // one expected result word
  typedef struct packed {
    logic signed [VAL_W-1:0] frc;
    logic signed [VAL_W-1:0] nrg;
    status_t                 st;
  } outcome_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_FIXED,
    ROW_CFG
  } row_kind_t;

  // one row of the directed plan
  typedef struct packed {
    row_kind_t           kind;
    logic [ACT_W-1:0]    act;
    logic [IDX_W-1:0]    idx;
    logic [VAL_W-1:0]    val;
    logic [DIST_W-1:0]   sep;
    cfg_reg_t            sel;
    logic [DIST_W-1:0]   cfg_data;
    outcome_t            want;
  } step_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action;
  logic [IDX_W-1:0]         in_entry_index;
  logic signed [VAL_W-1:0]  in_entry_value;
  logic [DIST_W-1:0]        in_distance;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_force_value;
  logic signed [VAL_W-1:0]  out_energy_value;
  logic [STAT_W-1:0]        out_status;
  logic                     cfg_wr_en;
  logic [CIDX_W-1:0]        cfg_index;
  logic [DIST_W-1:0]        cfg_wr_data;

  // predictor state
  logic [VAL_W-1:0]  force_mem  [TABLE_DEPTH_DFLT];
  logic [VAL_W-1:0]  energy_mem [TABLE_DEPTH_DFLT];
  bit                force_loaded  [TABLE_DEPTH_DFLT];
  bit                energy_loaded [TABLE_DEPTH_DFLT];
  logic [DIST_W-1:0] cur_r_min     = R_MIN_RST;
  logic [DIST_W-1:0] cur_inv_dr    = INV_DR_RST;
  logic [LEN_W-1:0]  cur_table_len = TABLE_LEN_RST;

  outcome_t    pending_results[$];
  step_row_t   plan[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;
  bit          pace_idle = 1'b1;
  bit          stall_on = 1'b1;

  pair_potential_table_interpolator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .in_distance      (in_distance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_force_value  (out_force_value),
    .out_energy_value (out_energy_value),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scaled index of a distance and whether the pair k, k+1 is inside the table
  function automatic status_t locate_index(input logic [DIST_W-1:0] sep,
                                           output logic [K_W-1:0] k,
                                           output logic [FRAC_W-1:0] frac);
    logic [DIST_W-1:0]   diff;
    logic [PROD_W-1:0]   prod;
    logic [LEN_W-1:0]    lim;
    k = '0;
    frac = '0;
    if (sep < cur_r_min) return ST_BELOW;
    diff = sep - cur_r_min;
    prod = PROD_W'(diff) * PROD_W'(cur_inv_dr);
    k = prod[PROD_W-1 -: K_W];
    frac = prod[PROD_W-K_W-1 -: FRAC_W];
    lim = (cur_table_len < LEN_W'(TABLE_DEPTH_DFLT)) ? cur_table_len
                                                      : LEN_W'(TABLE_DEPTH_DFLT);
    if (LIM_W'(k) + LIM_W'(1) >= LIM_W'(lim)) return ST_RANGE;
    return ST_OK;
  endfunction

  // weighted sum of two neighbor entries, floor shifts, saturated to 32 bits
  function automatic logic signed [VAL_W-1:0] lerp_entry(input logic signed [VAL_W-1:0] lo,
                                                         input logic signed [VAL_W-1:0] hi,
                                                         input logic [FRAC_W-1:0] frac);
    logic signed [17:0] w_hi;
    logic signed [17:0] w_lo;
    logic signed [49:0] p_hi;
    logic signed [49:0] p_lo;
    logic signed [50:0] total;
    w_hi = 18'(frac);
    w_lo = 18'sd65536 - w_hi;
    p_hi = w_hi * hi;
    p_lo = w_lo * lo;
    total = p_hi >>> FRAC_W;
    total = total + (p_lo >>> FRAC_W);
    if (total > 51'sd2147483647) return 32'sh7FFFFFFF;
    if (total < -51'sd2147483648) return 32'sh80000000;
    return total[VAL_W-1:0];
  endfunction

  // expected result of one accepted word; loads update the predictor tables
  function automatic outcome_t predict_word(input logic [ACT_W-1:0] act,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [VAL_W-1:0] val,
                                            input logic [DIST_W-1:0] sep);
    outcome_t          res;
    logic [K_W-1:0]    k;
    logic [FRAC_W-1:0] frac;
    res = '{frc: '0, nrg: '0, st: ST_OK};
    case (act)
      ACT_LOAD_FORCE: begin
        force_mem[idx] = val;
        force_loaded[idx] = 1'b1;
      end
      ACT_LOAD_ENERGY: begin
        energy_mem[idx] = val;
        energy_loaded[idx] = 1'b1;
      end
      ACT_QUERY: begin
        res.st = locate_index(sep, k, frac);
        if (res.st == ST_OK) begin
          res.frc = lerp_entry(force_mem[IDX_W'(k)], force_mem[IDX_W'(k + 1)], frac);
          res.nrg = lerp_entry(energy_mem[IDX_W'(k)], energy_mem[IDX_W'(k + 1)], frac);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // directed plan rows
  function automatic step_row_t word_row(input logic [ACT_W-1:0] act,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W-1:0] val,
                                         input logic [DIST_W-1:0] sep);
    step_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.act = act;
    r.idx = idx;
    r.val = val;
    r.sep = sep;
    return r;
  endfunction

  function automatic step_row_t fixed_row(input logic [ACT_W-1:0] act,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [VAL_W-1:0] val,
                                          input logic [DIST_W-1:0] sep,
                                          input logic [VAL_W-1:0] frc,
                                          input logic [VAL_W-1:0] nrg,
                                          input status_t st);
    step_row_t r;
    r = word_row(act, idx, val, sep);
    r.kind = ROW_FIXED;
    r.want = '{frc: frc, nrg: nrg, st: st};
    return r;
  endfunction

  function automatic step_row_t cfg_row(input cfg_reg_t sel, input logic [DIST_W-1:0] data);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.cfg_data = data;
    return r;
  endfunction

  // offer one word, wait for the handshake, then queue its expected result
  task automatic push_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [DIST_W-1:0] sep,
                           input bit fixed, input outcome_t fixed_out);
    outcome_t res;
    while (pace_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_distance    <= sep;
    do @(posedge clk); while (in_stall);
    words_sent++;
    res = predict_word(act, idx, val, sep);
    if (fixed) res = fixed_out;
    pending_results.push_back(res);
  endtask

  // hold the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [DIST_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= sel;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (sel)
      CFG_R_MIN:     cur_r_min = data;
      CFG_INV_DR:    cur_inv_dr = data;
      CFG_TABLE_LEN: cur_table_len = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // one random phase under a fixed register setting; n counts every word sent
  task automatic run_phase(input logic [DIST_W-1:0] r_min, input logic [DIST_W-1:0] inv_dr,
                           input logic [LEN_W-1:0] len, input int n, input bit calm);
    int unsigned       pick;
    int unsigned       lim;
    int                start_count;
    longint unsigned   s;
    longint unsigned   diff_l;
    logic [DIST_W-1:0] sep;
    logic [K_W-1:0]    k;
    logic [FRAC_W-1:0] frac;
    status_t           st;
    drain_results();
    pace_idle = !calm;
    stall_on = !calm;
    write_reg(CFG_R_MIN, r_min);
    write_reg(CFG_INV_DR, inv_dr);
    write_reg(CFG_TABLE_LEN, DIST_W'(len));
    start_count = words_sent;
    while (words_sent - start_count < n) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        push_word($urandom_range(1) ? ACT_LOAD_ENERGY : ACT_LOAD_FORCE, IDX_W'($urandom),
                  $urandom, DIST_W'($urandom), 1'b0, '0);
      end else if (pick < 27) begin
        push_word(ACT_UNUSED, IDX_W'($urandom), $urandom, DIST_W'($urandom), 1'b0, '0);
      end else begin
        // mostly distances that land inside the table, some below r_min, some anywhere
        pick = $urandom_range(99);
        lim = (cur_table_len < TABLE_DEPTH_DFLT) ? cur_table_len : TABLE_DEPTH_DFLT;
        sep = DIST_W'($urandom);
        if (pick < 70 && lim >= 2 && cur_inv_dr != 0) begin
          s = $urandom_range((lim - 1) * FRAC_ONE - 1);
          diff_l = ((s << FRAC_W) | $urandom_range(FRAC_ONE - 1)) / cur_inv_dr;
          if (cur_r_min + diff_l <= 64'hFFFFFF) sep = DIST_W'(cur_r_min + diff_l);
        end else if (pick < 85 && cur_r_min != 0) begin
          sep = DIST_W'($urandom_range(cur_r_min - 1));
        end
        // load any neighbor entry the query would read before it was written
        st = locate_index(sep, k, frac);
        if (st == ST_OK) begin
          for (int j = 0; j < 2; j++) begin
            if (!force_loaded[IDX_W'(k + j)])
              push_word(ACT_LOAD_FORCE, IDX_W'(k + j), $urandom, DIST_W'($urandom), 1'b0, '0);
            if (!energy_loaded[IDX_W'(k + j)])
              push_word(ACT_LOAD_ENERGY, IDX_W'(k + j), $urandom, DIST_W'($urandom), 1'b0, '0);
          end
        end
        push_word(ACT_QUERY, IDX_W'($urandom), $urandom, sep, 1'b0, '0);
      end
    end
  endtask

  // result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        automatic outcome_t want = pending_results.pop_front();
        if (out_force_value !== want.frc) begin
          $error("force_value: expected %0d, got %0d", want.frc, out_force_value);
          mismatches++;
        end
        if (out_energy_value !== want.nrg) begin
          $error("energy_value: expected %0d, got %0d", want.nrg, out_energy_value);
          mismatches++;
        end
        if (out_status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_status);
          mismatches++;
        end
      end
    end
    out_stall <= stall_on && ($urandom_range(99) < 33);
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pair_potential_table_interpolator_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_LOAD_FORCE;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_distance    <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_R_MIN;
    cfg_wr_data    <= '0;

    // directed plan, run under the reset register values first
    plan.push_back(fixed_row(ACT_LOAD_FORCE, 10'd0, 32'h7FFFFFFF, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_ENERGY, 10'd0, 32'h80000000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_FORCE, 10'd1, 32'h80000000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_ENERGY, 10'd1, 32'h7FFFFFFF, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h000000, 32'h7FFFFFFF, 32'h80000000,
                             ST_OK));
    plan.push_back(word_row(ACT_QUERY, '0, '0, 24'h008000));
    plan.push_back(word_row(ACT_QUERY, 10'h3FF, 32'hFFFFFFFF, 24'h00FFFF));
    plan.push_back(fixed_row(ACT_LOAD_FORCE, 10'd1023, 32'hFFFFFFFF, 24'hFFFFFF, '0, '0,
                             ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_ENERGY, 10'd1023, 32'h00000000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_FORCE, 10'd255, 32'h00010000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_ENERGY, 10'd255, 32'hFFFF0000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_FORCE, 10'd256, 32'h00030000, '0, '0, '0, ST_OK));
    plan.push_back(fixed_row(ACT_LOAD_ENERGY, 10'd256, 32'h00000000, '0, '0, '0, ST_OK));
    plan.push_back(word_row(ACT_QUERY, '0, '0, 24'hFFFFFF));
    // unused action code gives an all-zero word
    plan.push_back(fixed_row(ACT_UNUSED, 10'h3FF, 32'hFFFFFFFF, 24'hFFFFFF, '0, '0, ST_OK));
    // distance below r_min, then exactly at it
    plan.push_back(cfg_row(CFG_R_MIN, 24'h010000));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h00FFFF, '0, '0, ST_BELOW));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h010000, 32'h7FFFFFFF, 32'h80000000,
                             ST_OK));
    // shortest legal table: index 1 has no right neighbor
    plan.push_back(cfg_row(CFG_TABLE_LEN, 24'd2));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h020000, '0, '0, ST_RANGE));
    plan.push_back(word_row(ACT_QUERY, '0, '0, 24'h01FFFF));
    // zero reciprocal collapses every query onto entry 0
    plan.push_back(cfg_row(CFG_INV_DR, 24'd0));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                             ST_OK));
    // table too short for any pair; below r_min still wins
    plan.push_back(cfg_row(CFG_TABLE_LEN, 24'd1));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h010000, '0, '0, ST_RANGE));
    plan.push_back(fixed_row(ACT_QUERY, '0, '0, 24'h000000, '0, '0, ST_BELOW));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(plan[i].sel, plan[i].cfg_data);
      end else begin
        push_word(plan[i].act, plan[i].idx, plan[i].val, plan[i].sep,
                  plan[i].kind == ROW_FIXED, plan[i].want);
      end
    end

    // random phases: reset setting without idling or stalls, extremes, then random settings
    run_phase(R_MIN_RST, INV_DR_RST, TABLE_LEN_RST, 250, 1'b1);
    run_phase(24'h002000, 24'h040000, 11'd1024, 300, 1'b0);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 11'd1024, 60, 1'b0);
    run_phase(24'h000000, 24'hFFFFFF, 11'd2, 80, 1'b0);
    run_phase(24'h000000, 24'h000001, 11'd1024, 80, 1'b0);
    repeat (3) begin
      run_phase(DIST_W'($urandom_range(24'h7FFFFF)), DIST_W'($urandom_range(24'h0FFFFF, 1)),
                LEN_W'($urandom_range(1024, 2)), 160, 1'b0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pair_potential_table_interpolator_unit verification clean");
    end else begin
      $display("pair_potential_table_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule
